// ===== src/apu_seq_pkg.sv =====
// Shared types, constants and helper functions for the APU control sequencer.
`timescale 1ns / 1ps
package apu_seq_pkg;

  localparam int unsigned NumRegs = 23;
  localparam logic [4:0] SweepReg  = 5'd0;
  localparam logic [4:0] MasterReg = 5'd22;
  localparam logic [4:0] Ch1LoReg  = 5'd3;
  localparam logic [4:0] Ch1HiReg  = 5'd4;
  localparam logic [4:0] Ch3PowerReg = 5'd10;

  // per-channel register offsets, element i is channel i
  localparam logic [3:0][4:0] LenIdx = {5'd16, 5'd11, 5'd6, 5'd1};
  localparam logic [3:0][4:0] HiIdx  = {5'd19, 5'd14, 5'd9, 5'd4};
  localparam logic [3:0][4:0] EnvIdx = {5'd17, 5'd0, 5'd7, 5'd2};

  typedef struct packed {
    logic [NumRegs-1:0][7:0] regs;
    logic [2:0]              step;
    logic [3:0][8:0]         len;
    logic [3:0]              active;
    logic [3:0]              powered;
    logic [3:0]              len_en;
    logic [3:0][3:0]         vol;
    logic [3:0][3:0]         env_tmr;
    logic [3:0][2:0]         env_per;
    logic [3:0]              env_up;
    logic [10:0]             freq1;
    logic [3:0]              sw_tmr;
    logic [10:0]             sw_shadow;
    logic                    sw_on;
    logic                    sw_neg;
    logic [2:0]              sw_per;
    logic [2:0]              sw_shift;
    logic                    sw_down;
  } st_t;

  // {overflow, next frequency}
  function automatic logic [11:0] sweep_target(input logic [10:0] sh, input logic [2:0] shift,
                                               input logic down);
    logic [10:0] d;
    logic [11:0] s;
    d = sh >> shift;
    if (down) begin
      s = {1'b0, sh - d};
    end else begin
      s = {1'b0, sh} + {1'b0, d};
    end
    return s;
  endfunction

  // drop unpowered channels and mirror active flags into the status register
  function automatic st_t refresh(input st_t s);
    st_t r;
    r = s;
    r.active = s.active & s.powered;
    r.regs[MasterReg] = {s.regs[MasterReg][7:4], r.active};
    return r;
  endfunction

endpackage

// ===== src/apu_length_envelope_sweep_sequencer.sv =====
// Top level: state and result registers with valid/ready handshake around the core.
// The result is registered and becomes valid in the cycle after a transaction is accepted.
// Throughput: one transaction per cycle while out_ready_i is high; the core is a single combinational pass.
// A new transaction is taken while the result register is empty or being drained.
// Reset (rst_ni low, asynchronous) clears all state, the step counter and out valid.
`timescale 1ns / 1ps
module apu_length_envelope_sweep_sequencer import apu_seq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [4:0]  reg_index_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  status_byte_o,
  output logic [10:0] ch1_frequency_o,
  output logic [3:0]  volume_ch1_o,
  output logic [3:0]  volume_ch2_o,
  output logic [3:0]  volume_ch4_o,
  output logic [3:0]  restart_mask_o
);

  st_t        state_q, state_d;
  logic [3:0] mask_d, mask_q;
  logic       out_valid_q;
  logic       accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;

  apu_seq_core u_core (
    .st_i  (state_q),
    .mode_i(mode_i),
    .idx_i (reg_index_i),
    .data_i(write_data_i),
    .st_o  (state_d),
    .mask_o(mask_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) state_q <= state_d;
      if (accept) mask_q <= mask_d;
      if (accept) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_byte_o = state_q.regs[MasterReg];
  assign ch1_frequency_o = state_q.freq1;
  assign volume_ch1_o = state_q.vol[0];
  assign volume_ch2_o = state_q.vol[1];
  assign volume_ch4_o = state_q.vol[3];
  assign restart_mask_o = mask_q;

  a_active_powered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.active & ~state_q.powered) == 4'd0) else $error("active channel unpowered");
  a_master_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.regs[MasterReg][7] |-> state_q.active == 4'd0)
    else $error("channel active with master off");
  a_mask_master: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && restart_mask_o != 4'd0) |-> status_byte_o[7])
    else $error("restart reported with master off");
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o) else $error("accepted transaction produced no result");

endmodule

// ===== src/apu_seq_core.sv =====
// Next-state logic: applies one register write or one sequencer tick.
`timescale 1ns / 1ps
module apu_seq_core import apu_seq_pkg::*; (
  input  st_t        st_i,
  input  logic       mode_i,
  input  logic [4:0] idx_i,
  input  logic [7:0] data_i,
  output st_t        st_o,
  output logic [3:0] mask_o
);

  always_comb begin
    st_t         n;
    logic [3:0]  mask;
    logic [7:0]  old_sweep;
    logic [7:0]  hi;
    logic [7:0]  env;
    logic        old_master;
    logic        master;
    logic        wrote;
    logic        odd;
    logic        trig;
    logic        prev_len;
    logic [2:0]  step;
    logic [11:0] tgt;
    logic [11:0] tgt2;
    n = st_i;
    mask = '0;
    old_sweep = st_i.regs[SweepReg];
    old_master = st_i.regs[MasterReg][7];
    master = 1'b0;
    hi = '0;
    env = '0;
    wrote = 1'b0;
    odd = 1'b0;
    trig = 1'b0;
    prev_len = 1'b0;
    step = st_i.step;
    tgt = '0;
    tgt2 = '0;
    if (mode_i) begin
      if (st_i.regs[MasterReg][7]) begin
        n.step = step + 3'd1;
        if ((step == 3'd2 || step == 3'd6) && n.active[0] && n.sw_on) begin
          if (n.sw_tmr != 4'd0) n.sw_tmr = n.sw_tmr - 4'd1;
          if (n.sw_tmr == 4'd0) begin
            if (n.sw_per != 3'd0) begin
              n.sw_tmr = {1'b0, n.sw_per};
              tgt = sweep_target(n.sw_shadow, n.sw_shift, n.sw_down);
              if (tgt[11]) begin
                n.active[0] = 1'b0;
              end else if (n.sw_down) begin
                n.sw_neg = 1'b1;
              end
              if (!tgt[11] && n.sw_shift != 3'd0) begin
                n.sw_shadow = tgt[10:0];
                n.freq1 = tgt[10:0];
                n.regs[Ch1LoReg] = tgt[7:0];
                n.regs[Ch1HiReg] = (n.regs[Ch1HiReg] & 8'h78) | {5'd0, tgt[10:8]};
                tgt2 = sweep_target(tgt[10:0], n.sw_shift, n.sw_down);
                if (tgt2[11]) n.active[0] = 1'b0;
              end
            end else begin
              n.sw_tmr = 4'd8;
            end
          end
        end
        if (step == 3'd7) begin
          for (int i = 0; i < 4; i++) begin
            if (i != 2 && n.env_per[i] != 3'd0) begin
              if (n.env_tmr[i] != 4'd0) n.env_tmr[i] = n.env_tmr[i] - 4'd1;
              if (n.env_tmr[i] == 4'd0) begin
                n.env_tmr[i] = {1'b0, n.env_per[i]};
                if (n.env_up[i]) begin
                  if (n.vol[i] != 4'hF) n.vol[i] = n.vol[i] + 4'd1;
                end else begin
                  if (n.vol[i] != 4'h0) n.vol[i] = n.vol[i] - 4'd1;
                end
              end
            end
          end
        end
        if (!step[0]) begin
          for (int i = 0; i < 4; i++) begin
            if (n.len_en[i]) begin
              if (n.len[i] != 9'd0) n.len[i] = n.len[i] - 9'd1;
              if (n.len[i] == 9'd0) n.active[i] = 1'b0;
            end
          end
        end
        n = refresh(n);
      end
    end else if (idx_i < 5'(NumRegs)) begin
      n.regs[idx_i] = data_i;
      master = n.regs[MasterReg][7];
      if (!old_master && master) n.step = 3'd0;
      for (int i = 0; i < 4; i++) begin
        if (idx_i == LenIdx[i]) begin
          if (i == 2) n.len[i] = 9'd256 - {1'b0, data_i};
          else        n.len[i] = 9'd64 - {3'd0, data_i[5:0]};
        end
      end
      if (!master) begin
        n.active = '0;
        n.powered = '0;
      end else begin
        n.sw_per = n.regs[SweepReg][6:4];
        n.sw_shift = n.regs[SweepReg][2:0];
        n.sw_down = n.regs[SweepReg][3];
        for (int i = 0; i < 4; i++) begin
          hi = n.regs[HiIdx[i]];
          env = (i == 2) ? 8'd0 : n.regs[EnvIdx[i]];
          prev_len = n.len_en[i];
          wrote = (idx_i == HiIdx[i]);
          odd = n.step[0];
          trig = wrote && hi[7];
          n.len_en[i] = hi[6];
          if (i == 2) begin
            n.powered[i] = n.regs[Ch3PowerReg][7];
            n.env_up[i] = 1'b0;
            n.env_per[i] = 3'd0;
          end else begin
            n.powered[i] = (env[7:3] != 5'd0);
            n.env_up[i] = env[3];
            n.env_per[i] = env[2:0];
          end
          n.active[i] = n.active[i] && n.powered[i];
          if (i == 0) n.freq1 = {hi[2:0], n.regs[Ch1LoReg]};
          if (wrote && n.len_en[i] && !prev_len && odd && n.len[i] != 9'd0) begin
            n.len[i] = n.len[i] - 9'd1;
            if (n.len[i] == 9'd0 && !trig) n.active[i] = 1'b0;
          end
          if (trig) begin
            mask[i] = 1'b1;
            n.vol[i] = env[7:4];
            if (n.len[i] == 9'd0) begin
              n.len[i] = (i == 2) ? 9'd256 : 9'd64;
              if (n.len_en[i] && odd) n.len[i] = n.len[i] - 9'd1;
            end
            n.env_tmr[i] = (n.env_per[i] != 3'd0) ? {1'b0, n.env_per[i]} : 4'd8;
            n.active[i] = 1'b1;
            if (i == 0) begin
              n.sw_shadow = n.freq1;
              n.sw_neg = 1'b0;
              n.sw_on = (n.sw_per != 3'd0) || (n.sw_shift != 3'd0);
              n.sw_tmr = (n.sw_per != 3'd0) ? {1'b0, n.sw_per} : 4'd8;
              tgt = sweep_target(n.freq1, n.sw_shift, n.sw_down);
              if (n.sw_shift != 3'd0 && n.sw_down && !tgt[11]) n.sw_neg = 1'b1;
              if (n.sw_shift != 3'd0 && tgt[11]) n.active[0] = 1'b0;
            end
          end
          // leaving negate mode after a negated calculation kills channel 1
          if (i == 0 && idx_i == SweepReg && old_sweep[3] && !n.regs[SweepReg][3] &&
              n.sw_neg) begin
            n.active[0] = 1'b0;
            n.sw_on = 1'b0;
          end
          n.regs[HiIdx[i]] = hi & 8'h7F;
        end
      end
      n = refresh(n);
    end
    st_o = n;
    mask_o = mask;
  end

endmodule
